>>> design/sst_pkg.sv
package sst_pkg;

    // Table size and derived widths
    localparam int CAPACITY    = 16;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // Fixed field widths
    localparam int REQ_W       = 2;
    localparam int VAL_W       = 8;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    // Request queue between front and back (depth a power of two, pointers wrap)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [REQ_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_DUMP   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NO_CHANGE = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic {
        BS_OP   = 1'b0,
        BS_DUMP = 1'b1
    } t_bstate;

    typedef struct packed {
        t_op                      op;
        logic signed [VAL_W-1:0]  value;
    } t_cmd;

    // Head of the request queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

    typedef struct packed {
        t_status                  status;
        logic                     found;
        logic                     has_element;
        logic signed [VAL_W-1:0]  element;
        logic                     last;
        logic [COUNT_OUT_W-1:0]   entry_count;
    } t_rsp;

endpackage

>>> design/sst_req_if.sv
interface sst_req_if import sst_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic signed [VAL_W-1:0]  value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

>>> design/sst_rsp_if.sv
interface sst_rsp_if import sst_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic                     found;
    logic                     has_element;
    logic signed [VAL_W-1:0]  element;
    logic                     last;
    logic [COUNT_OUT_W-1:0]   entry_count;

    modport source (output valid, output status, output found, output has_element,
                    output element, output last, output entry_count, input ready);
    modport sink   (input valid, input status, input found, input has_element,
                    input element, input last, input entry_count, output ready);
endinterface

>>> design/sst_front.sv
module sst_front import sst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sst_req_if.sink     i_req,
    input  logic        i_pop,
    output t_qhead      o_head
);

    t_cmd                r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QFILL_W-1:0]  r_fill;
    logic                push;
    logic                pop;
    t_cmd                new_cmd;

    // Classify the incoming request
    always_comb begin
        new_cmd.op    = t_op'(i_req.req_type);
        new_cmd.value = i_req.value;
    end

    assign i_req.ready = (r_fill != QFILL_W'(QUEUE_DEPTH));
    assign push        = i_req.valid && i_req.ready;
    assign pop         = i_pop && (r_fill != '0);

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= new_cmd;
        end
    end

    // Queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_fill <= r_fill + QFILL_W'(1);
                2'b01:   r_fill <= r_fill - QFILL_W'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

    assign o_head.valid = (r_fill != '0);
    assign o_head.cmd   = r_q[r_rd_ptr];

endmodule

>>> design/sst_back.sv
module sst_back import sst_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_qhead  i_head,
    output logic    o_pop,
    output logic    o_rsp_valid,
    input  logic    i_rsp_ready,
    output t_rsp    o_rsp
);

    logic signed [VAL_W-1:0]  r_entries [CAPACITY];
    logic signed [VAL_W-1:0]  n_entries [CAPACITY];
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [IDX_W-1:0]         r_idx;
    logic [IDX_W-1:0]         n_idx;
    t_bstate                  r_state;
    t_bstate                  n_state;
    logic                     r_rsp_valid;
    t_rsp                     r_rsp;
    t_rsp                     n_rsp;

    logic [CAPACITY-1:0]      cell_valid;
    logic [CAPACITY-1:0]      cell_lt;
    logic [CAPACITY-1:0]      cell_eq;
    logic                     hit;
    logic                     out_free;
    logic                     emit;
    logic                     do_ins;
    logic                     do_rem;
    logic                     dump_last;
    logic signed [VAL_W-1:0]  v;

    assign v        = i_head.cmd.value;
    assign out_free = !r_rsp_valid || i_rsp_ready;
    assign hit      = |cell_eq;

    // Compare-and-shift cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        assign cell_valid[i] = (CNT_W'(i) < r_count);
        assign cell_lt[i]    = cell_valid[i] && (r_entries[i] < v);
        assign cell_eq[i]    = cell_valid[i] && (r_entries[i] == v);

        logic signed [VAL_W-1:0] ins_val;
        logic signed [VAL_W-1:0] rem_val;

        // Insert: entries below v stay, the first slot takes v, the rest move up
        if (i == 0) begin : g_ins_first
            assign ins_val = cell_lt[i] ? r_entries[i] : v;
        end else begin : g_ins_rest
            always_comb begin
                if (cell_lt[i]) begin
                    ins_val = r_entries[i];
                end else if (cell_lt[i-1]) begin
                    ins_val = v;
                end else if (cell_valid[i-1]) begin
                    ins_val = r_entries[i-1];
                end else begin
                    ins_val = r_entries[i];
                end
            end
        end

        // Remove: entries at or above v move down one place
        if (i == CAPACITY - 1) begin : g_rem_top
            assign rem_val = r_entries[i];
        end else begin : g_rem_rest
            assign rem_val = (cell_valid[i] && !cell_lt[i]) ? r_entries[i+1] : r_entries[i];
        end

        always_comb begin
            if (do_ins) begin
                n_entries[i] = ins_val;
            end else if (do_rem) begin
                n_entries[i] = rem_val;
            end else begin
                n_entries[i] = r_entries[i];
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_OP: begin
                if (i_head.valid && out_free && i_head.cmd.op == OP_DUMP
                        && r_count > CNT_W'(1)) begin
                    n_state = BS_DUMP;
                end
            end
            BS_DUMP: begin
                if (out_free && dump_last) begin
                    n_state = BS_OP;
                end
            end
            default: n_state = BS_OP;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_pop     = 1'b0;
        emit      = 1'b0;
        do_ins    = 1'b0;
        do_rem    = 1'b0;
        n_count   = r_count;
        n_idx     = r_idx;
        dump_last = (CNT_W'(r_idx) + CNT_W'(1) == r_count);
        n_rsp     = r_rsp;
        case (r_state)
            BS_OP: begin
                if (i_head.valid && out_free) begin
                    o_pop             = 1'b1;
                    emit              = 1'b1;
                    n_rsp.status      = ST_DONE;
                    n_rsp.found       = 1'b0;
                    n_rsp.has_element = 1'b0;
                    n_rsp.element     = '0;
                    n_rsp.last        = 1'b1;
                    case (i_head.cmd.op)
                        OP_INSERT: begin
                            if (hit) begin
                                n_rsp.status = ST_NO_CHANGE;
                            end else if (r_count == CNT_W'(CAPACITY)) begin
                                n_rsp.status = ST_FULL;
                            end else begin
                                do_ins  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_REMOVE: begin
                            if (!hit) begin
                                n_rsp.status = ST_NO_CHANGE;
                            end else begin
                                do_rem  = 1'b1;
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        OP_SEARCH: begin
                            n_rsp.found = hit;
                        end
                        OP_DUMP: begin
                            if (r_count != '0) begin
                                n_rsp.has_element = 1'b1;
                                n_rsp.element     = r_entries[0];
                                n_rsp.last        = (r_count == CNT_W'(1));
                                n_idx             = IDX_W'(1);
                            end
                        end
                        default: n_rsp.status = ST_DONE;
                    endcase
                    n_rsp.entry_count = COUNT_OUT_W'(n_count);
                end
            end
            BS_DUMP: begin
                if (out_free) begin
                    emit              = 1'b1;
                    n_rsp.status      = ST_DONE;
                    n_rsp.found       = 1'b0;
                    n_rsp.has_element = 1'b1;
                    n_rsp.element     = r_entries[r_idx];
                    n_rsp.last        = dump_last;
                    n_rsp.entry_count = COUNT_OUT_W'(r_count);
                    n_idx             = r_idx + IDX_W'(1);
                end
            end
            default: emit = 1'b0;
        endcase
    end

    // Table cells, no reset: only entries below the count are read
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            r_entries[i] <= n_entries[i];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_OP;
            r_count     <= '0;
            r_idx       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (emit) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

>>> design/sorted_set_table_unit.sv
// Sorted set table: keeps up to 16 distinct signed bytes in ascending order.
// Requests (insert, remove, search, dump) enter a two-deep queue, so up to two
// requests wait there while the response side stalls. Insert, remove and search
// each pass once through the row of compare-and-shift cells and give one
// response; dump gives one response per stored entry, one per cycle while
// responses are taken (one response when the table is empty), with last set
// on the final one. A full table rejects an insert with status 2; a duplicate
// insert or a remove of an absent value reports status 1 and leaves the table
// as it was. Every response carries the entry count after the request.
// Requests pass the queue, and responses are registered and wait for ready
// without blocking the queue from filling.
module sorted_set_table_unit import sst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sst_req_if.sink     i_req,
    sst_rsp_if.source   o_rsp
);

    t_qhead  head;
    logic    pop;
    logic    rsp_valid;
    t_rsp    rsp;

    sst_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_pop   (pop),
        .o_head  (head)
    );

    sst_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp       (rsp)
    );

    // Drive the response channel
    assign o_rsp.valid       = rsp_valid;
    assign o_rsp.status      = STATUS_W'(rsp.status);
    assign o_rsp.found       = rsp.found;
    assign o_rsp.has_element = rsp.has_element;
    assign o_rsp.element     = rsp.element;
    assign o_rsp.last        = rsp.last;
    assign o_rsp.entry_count = rsp.entry_count;

endmodule

>>> sim/sorted_set_table_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the sorted set table, keeps its own copy of the set,
// and compares every response against the oldest predicted one.
module sorted_set_table_checker import sst_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    input  logic                     i_req_ready,
    input  logic [REQ_W-1:0]         i_req_type,
    input  logic signed [VAL_W-1:0]  i_req_value,
    input  logic                     i_rsp_valid,
    input  logic                     i_rsp_ready,
    input  logic [STATUS_W-1:0]      i_rsp_status,
    input  logic                     i_rsp_found,
    input  logic                     i_rsp_has_element,
    input  logic signed [VAL_W-1:0]  i_rsp_element,
    input  logic                     i_rsp_last,
    input  logic [COUNT_OUT_W-1:0]   i_rsp_entry_count,
    output int                       o_fail_count,
    output int                       o_pending
);

    // Shadow copy of the set and the responses still owed
    logic signed [VAL_W-1:0] set_entries [CAPACITY];
    int                      set_size;
    t_rsp                    owed_rsp_q[$];
    int                      fail_count;

    initial begin
        set_size     = 0;
        fail_count   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Response fields as they stand after the current request
    function automatic t_rsp make_rsp(t_status st, logic fnd, logic has_el,
                                      logic signed [VAL_W-1:0] el, logic lst);
        t_rsp r;
        r.status      = st;
        r.found       = fnd;
        r.has_element = has_el;
        r.element     = el;
        r.last        = lst;
        r.entry_count = COUNT_OUT_W'(set_size);
        return r;
    endfunction

    function automatic int find_entry(logic signed [VAL_W-1:0] v);
        for (int i = 0; i < set_size; i++) begin
            if (set_entries[i] == v) return i;
        end
        return -1;
    endfunction

    // Apply one request to the shadow set and queue what it must produce
    task automatic predict_request(t_op op, logic signed [VAL_W-1:0] v);
        int pos;
        pos = find_entry(v);
        case (op)
            OP_INSERT: begin
                // duplicate wins over full
                if (pos >= 0) begin
                    owed_rsp_q.push_back(make_rsp(ST_NO_CHANGE, 1'b0, 1'b0, '0, 1'b1));
                end else if (set_size >= CAPACITY) begin
                    owed_rsp_q.push_back(make_rsp(ST_FULL, 1'b0, 1'b0, '0, 1'b1));
                end else begin
                    pos = set_size;
                    while (pos > 0 && set_entries[pos-1] > v) begin
                        set_entries[pos] = set_entries[pos-1];
                        pos--;
                    end
                    set_entries[pos] = v;
                    set_size++;
                    owed_rsp_q.push_back(make_rsp(ST_DONE, 1'b0, 1'b0, '0, 1'b1));
                end
            end
            OP_REMOVE: begin
                if (pos < 0) begin
                    owed_rsp_q.push_back(make_rsp(ST_NO_CHANGE, 1'b0, 1'b0, '0, 1'b1));
                end else begin
                    for (int i = pos; i + 1 < set_size; i++) set_entries[i] = set_entries[i+1];
                    set_size--;
                    owed_rsp_q.push_back(make_rsp(ST_DONE, 1'b0, 1'b0, '0, 1'b1));
                end
            end
            OP_SEARCH: begin
                owed_rsp_q.push_back(make_rsp(ST_DONE, pos >= 0, 1'b0, '0, 1'b1));
            end
            default: begin
                // empty dump still gives one response
                if (set_size == 0) begin
                    owed_rsp_q.push_back(make_rsp(ST_DONE, 1'b0, 1'b0, '0, 1'b1));
                end else begin
                    for (int i = 0; i < set_size; i++) begin
                        owed_rsp_q.push_back(make_rsp(ST_DONE, 1'b0, 1'b1, set_entries[i],
                                                      i == set_size - 1));
                    end
                end
            end
        endcase
    endtask

    // Compare responses first, then predict the request of the same edge
    always @(posedge i_clk) begin : watch
        t_rsp got;
        t_rsp want;
        logic bad;
        if (!i_rst_n) begin
            set_size = 0;
            owed_rsp_q.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                got.status      = t_status'(i_rsp_status);
                got.found       = i_rsp_found;
                got.has_element = i_rsp_has_element;
                got.element     = i_rsp_element;
                got.last        = i_rsp_last;
                got.entry_count = i_rsp_entry_count;
                if (owed_rsp_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected response st=%0d fnd=%0d has=%0d el=%0d last=%0d cnt=%0d",
                                 $realtime, got.status, got.found, got.has_element,
                                 got.element, got.last, got.entry_count);
                end else begin
                    want = owed_rsp_q.pop_front();
                    bad  = (got.status !== want.status) || (got.found !== want.found) ||
                           (got.has_element !== want.has_element) ||
                           (got.element !== want.element) || (got.last !== want.last) ||
                           (got.entry_count !== want.entry_count);
                    if (bad) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch exp st=%0d fnd=%0d has=%0d el=%0d last=%0d cnt=%0d / got st=%0d fnd=%0d has=%0d el=%0d last=%0d cnt=%0d",
                                     $realtime, want.status, want.found, want.has_element,
                                     want.element, want.last, want.entry_count,
                                     got.status, got.found, got.has_element,
                                     got.element, got.last, got.entry_count);
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                predict_request(t_op'(i_req_type), i_req_value);
        end
        o_pending    = owed_rsp_q.size();
        o_fail_count = fail_count;
    end

endmodule

>>> sim/sorted_set_table_unit_tb.sv
`timescale 1ns / 100ps

// Drives requests and response back-pressure into the sorted set table and
// gives the verdict from the checker's failure count.
module sorted_set_table_unit_tb;
    import sst_pkg::*;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;

    sst_req_if req_if ();
    sst_rsp_if rsp_if ();

    sorted_set_table_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    sorted_set_table_checker table_watch (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (req_if.valid),
        .i_req_ready       (req_if.ready),
        .i_req_type        (req_if.req_type),
        .i_req_value       (req_if.value),
        .i_rsp_valid       (rsp_if.valid),
        .i_rsp_ready       (rsp_if.ready),
        .i_rsp_status      (rsp_if.status),
        .i_rsp_found       (rsp_if.found),
        .i_rsp_has_element (rsp_if.has_element),
        .i_rsp_element     (rsp_if.element),
        .i_rsp_last        (rsp_if.last),
        .i_rsp_entry_count (rsp_if.entry_count),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // 2 ns clock
    always #1 i_clk = ~i_clk;

    // Hard stop
    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

    // Mostly values from a small pool so removes hit and duplicates occur
    function automatic logic signed [VAL_W-1:0] pick_value();
        int idx;
        idx = $urandom_range(0, 31);
        if (idx >= 24) return VAL_W'($urandom);
        if (idx == 0) return VAL_W'(-128);
        if (idx == 23) return VAL_W'(127);
        return VAL_W'(idx * 11 - 128);
    endfunction

    function automatic t_op pick_op(int ins_w, int rem_w, int srch_w);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_w) return OP_INSERT;
        if (r < ins_w + rem_w) return OP_REMOVE;
        if (r < ins_w + rem_w + srch_w) return OP_SEARCH;
        return OP_DUMP;
    endfunction

    // One request: optional idle gap, then hold until accepted
    task automatic send_request(t_op op, logic signed [VAL_W-1:0] v, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= op;
        req_if.value    <= v;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
        @(negedge i_clk);
    endtask

    // Stop offering and wait for every owed response
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic run_phase(int n, int ins_w, int rem_w, int srch_w, bit wide);
        t_op                     op;
        logic signed [VAL_W-1:0] v;
        for (int k = 0; k < n; k++) begin
            op = pick_op(ins_w, rem_w, srch_w);
            v  = wide ? VAL_W'($urandom) : pick_value();
            send_request(op, v, (k % 40) < 8);
        end
    endtask

    // Response side: random stalls, bursts with none, and long hold-offs
    initial begin
        int stall;
        int taken;
        rsp_if.ready = 1'b0;
        taken        = 0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = (((taken / 50) % 3) == 0) ? 0 : $urandom_range(0, 3);
            repeat (stall) begin
                rsp_if.ready <= 1'b0;
                @(negedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_if.valid && rsp_if.ready));
            @(negedge i_clk);
            taken++;
            // hold off long enough for the request queue to back up
            if (taken == 120 || taken == 300 || taken == 450) begin
                rsp_if.ready <= 1'b0;
                repeat (80) @(negedge i_clk);
            end
        end
    end

    // Request side
    initial begin
        req_if.valid    = 1'b0;
        req_if.req_type = OP_INSERT;
        req_if.value    = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, duplicate, absent remove/search, empty dump
        send_request(OP_INSERT, VAL_W'(127), 1'b0);
        send_request(OP_INSERT, VAL_W'(-128), 1'b0);
        send_request(OP_INSERT, VAL_W'(0), 1'b1);
        send_request(OP_INSERT, VAL_W'(-1), 1'b1);
        send_request(OP_INSERT, VAL_W'(0), 1'b0);
        send_request(OP_SEARCH, VAL_W'(127), 1'b0);
        send_request(OP_SEARCH, VAL_W'(5), 1'b0);
        send_request(OP_DUMP, VAL_W'(-1), 1'b1);
        send_request(OP_REMOVE, VAL_W'(5), 1'b0);
        send_request(OP_REMOVE, VAL_W'(-128), 1'b0);
        send_request(OP_REMOVE, VAL_W'(127), 1'b1);
        send_request(OP_REMOVE, VAL_W'(0), 1'b0);
        send_request(OP_REMOVE, VAL_W'(-1), 1'b0);
        send_request(OP_DUMP, VAL_W'(85), 1'b0);
        send_request(OP_SEARCH, VAL_W'(-128), 1'b0);
        send_request(OP_REMOVE, VAL_W'(0), 1'b0);
        wait_drained();

        // fill toward full, then mixed, then drain toward empty, then wide values
        run_phase(60, 70, 10, 10, 1'b0);
        wait_drained();
        run_phase(150, 35, 30, 20, 1'b0);
        wait_drained();
        run_phase(80, 15, 60, 10, 1'b0);
        run_phase(70, 25, 25, 25, 1'b1);

        // let the last responses and any stray ones arrive
        wait_drained();
        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
